@@ hdl/tpvs_pkg.sv @@
`default_nettype none

package tpvs_pkg;

  localparam int CordicSteps = 16;
  localparam int IterW       = $clog2(CordicSteps);

  localparam int PosW  = 24;
  localparam int HeadW = 16;
  localparam int VecW  = 34;
  localparam int AngW  = 25;
  localparam int LutW  = 5;

  localparam int FullTurn    = 46080;
  localparam int HalfTurn    = 23040;
  localparam int QuarterTurn = 11520;

  localparam int TurnSteps = 8;
  localparam int TurnBias  = FullTurn * (2 ** TurnSteps);

  localparam int LoW      = 17;
  localparam int MulW     = LoW + 1;
  localparam int GainW    = 31;
  localparam int ProdW    = MulW + GainW;
  localparam int AccW     = 64;
  localparam int ShiftOut = 38;

  localparam logic signed [GainW-1:0] GainQ30 = 31'sd652032874;
  localparam logic signed [AccW-1:0]  RoundC  = 64'sd1 <<< (ShiftOut - 1);

  typedef enum logic [1:0] {
    OP_MOVE = 2'd0,
    OP_TURN = 2'd1,
    OP_PEN  = 2'd2,
    OP_POSE = 2'd3
  } op_e;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ROT  = 8'b0000_0010,
    S_MXL  = 8'b0000_0100,
    S_MXH  = 8'b0000_1000,
    S_MYL  = 8'b0001_0000,
    S_MYH  = 8'b0010_0000,
    S_DONE = 8'b0100_0000,
    S_TURN = 8'b1000_0000
  } state_e;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [AngW-1:0] atan_lut(input logic [LutW-1:0] idx);
    logic signed [AngW-1:0] r;
    unique case (idx)
      5'd0:    r = 25'sd2949120;
      5'd1:    r = 25'sd1740967;
      5'd2:    r = 25'sd919879;
      5'd3:    r = 25'sd466945;
      5'd4:    r = 25'sd234379;
      5'd5:    r = 25'sd117305;
      5'd6:    r = 25'sd58666;
      5'd7:    r = 25'sd29335;
      5'd8:    r = 25'sd14668;
      5'd9:    r = 25'sd7334;
      5'd10:   r = 25'sd3667;
      5'd11:   r = 25'sd1833;
      5'd12:   r = 25'sd917;
      5'd13:   r = 25'sd458;
      5'd14:   r = 25'sd229;
      5'd15:   r = 25'sd115;
      5'd16:   r = 25'sd57;
      5'd17:   r = 25'sd29;
      5'd18:   r = 25'sd14;
      5'd19:   r = 25'sd7;
      5'd20:   r = 25'sd4;
      5'd21:   r = 25'sd2;
      5'd22:   r = 25'sd1;
      default: r = 25'sd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/tpvs_cmd_if.sv @@
`default_nettype none

interface tpvs_cmd_if;
  import tpvs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             operation;
  logic signed [PosW-1:0] amount;
  logic                   pen_value;
  logic signed [PosW-1:0] pose_x;
  logic signed [PosW-1:0] pose_y;
  logic [HeadW-1:0]       pose_heading;

  modport source (
    output valid, operation, amount, pen_value, pose_x, pose_y, pose_heading,
    input  ready
  );

  modport sink (
    input  valid, operation, amount, pen_value, pose_x, pose_y, pose_heading,
    output ready
  );

endinterface

`default_nettype wire

@@ hdl/tpvs_seg_if.sv @@
`default_nettype none

interface tpvs_seg_if;
  import tpvs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] start_x;
  logic signed [PosW-1:0] start_y;
  logic signed [PosW-1:0] end_x;
  logic signed [PosW-1:0] end_y;

  modport source (
    output valid, start_x, start_y, end_x, end_y,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, end_x, end_y,
    output ready
  );

endinterface

`default_nettype wire

@@ hdl/turtle_pose_vector_stepper_unit.sv @@
// move: the single shared cordic rotator and the 18x31 gain multiplier (4 passes) lead from accept
//   to the segment register; a move holds in S_DONE while the pen is down and an earlier segment waits
// turn: 8 passes of one compare-subtract reduce the heading modulo 360 degrees
// set pen and set pose stay in idle; a new command is taken while a segment waits
// async active-low reset: position 0, heading 0, pen down, no segment pending
`default_nettype none

module turtle_pose_vector_stepper_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tpvs_cmd_if.sink    cmd_i,
  tpvs_seg_if.source  seg_o
);
  import tpvs_pkg::*;

  state_e state_q, state_d;

  logic signed [VecW-1:0] x_q, x_d, y_q, y_d;
  logic signed [AngW-1:0] z_q, z_d;
  logic [IterW-1:0]       iter_q, iter_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic [PosW-1:0]        dx_q, dx_d;
  logic [PosW-1:0]        turn_q, turn_d;

  logic [PosW-1:0]  pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [HeadW-1:0] heading_q, heading_d;
  logic             pen_q, pen_d;

  logic            seg_valid_q, seg_valid_d;
  logic [PosW-1:0] sx_q, sx_d, sy_q, sy_d, ex_q, ex_d, ey_q, ey_d;

  logic                   cmd_fire;
  logic signed [VecW-1:0] dist_w, sh_x, sh_y;
  logic [HeadW-1:0]       h_fold;
  logic signed [AngW-1:0] turn_sum;
  logic signed [MulW-1:0] mul_a;
  logic signed [ProdW-1:0] prod;
  logic [PosW-1:0]        turn_w, dy_w, nx_w, ny_w;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;

  assign seg_o.valid   = seg_valid_q;
  assign seg_o.start_x = sx_q;
  assign seg_o.start_y = sy_q;
  assign seg_o.end_x   = ex_q;
  assign seg_o.end_y   = ey_q;

  // shared datapath pieces
  assign dist_w   = VecW'(cmd_i.amount) <<< 8;
  assign h_fold   = (heading_q >= HeadW'(HalfTurn)) ? heading_q - HeadW'(HalfTurn) : heading_q;
  assign turn_sum = AngW'($signed({1'b0, heading_q})) + AngW'(cmd_i.amount);
  assign sh_x     = x_q >>> iter_q;
  assign sh_y     = y_q >>> iter_q;
  assign turn_w   = PosW'(FullTurn) << iter_q;
  assign prod     = mul_a * GainQ30;
  assign dy_w     = acc_q[ShiftOut+PosW-1:ShiftOut];
  assign nx_w     = pos_x_q + dx_q;
  assign ny_w     = pos_y_q + dy_w;

  always_comb begin
    unique case (state_q)
      S_MXL:   mul_a = $signed({1'b0, x_q[LoW-1:0]});
      S_MXH:   mul_a = MulW'($signed(x_q[VecW-1:LoW]));
      S_MYL:   mul_a = $signed({1'b0, y_q[LoW-1:0]});
      S_MYH:   mul_a = MulW'($signed(y_q[VecW-1:LoW]));
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    iter_d      = iter_q;
    acc_d       = acc_q;
    dx_d        = dx_q;
    turn_d      = turn_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    heading_d   = heading_q;
    pen_d       = pen_q;
    seg_valid_d = seg_valid_q && !seg_o.ready;
    sx_d        = sx_q;
    sy_d        = sy_q;
    ex_d        = ex_q;
    ey_d        = ey_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_fire) begin
          unique case (op_e'(cmd_i.operation))
            OP_MOVE: begin
              // from 180 degrees up the start vector is negated
              x_d     = '0;
              y_d     = (heading_q >= HeadW'(HalfTurn)) ? -dist_w : dist_w;
              z_d     = (AngW'($signed({1'b0, h_fold})) - AngW'(QuarterTurn)) <<< 9;
              iter_d  = '0;
              state_d = S_ROT;
            end
            OP_TURN: begin
              turn_d  = turn_sum[AngW-1] ? PosW'(turn_sum + AngW'(TurnBias))
                                          : PosW'(turn_sum);
              iter_d  = IterW'(TurnSteps - 1);
              state_d = S_TURN;
            end
            OP_PEN: begin
              pen_d = cmd_i.pen_value;
            end
            OP_POSE: begin
              pos_x_d   = cmd_i.pose_x;
              pos_y_d   = cmd_i.pose_y;
              heading_d = (cmd_i.pose_heading >= HeadW'(FullTurn))
                        ? cmd_i.pose_heading - HeadW'(FullTurn) : cmd_i.pose_heading;
            end
            default: ;
          endcase
        end
      end
      S_ROT: begin
        if (!z_q[AngW-1]) begin
          x_d = x_q - sh_y;
          y_d = y_q + sh_x;
          z_d = z_q - atan_lut(LutW'(iter_q));
        end else begin
          x_d = x_q + sh_y;
          y_d = y_q - sh_x;
          z_d = z_q + atan_lut(LutW'(iter_q));
        end
        iter_d = iter_q + 1'b1;
        if (iter_q == IterW'(CordicSteps - 1)) begin
          state_d = S_MXL;
        end
      end
      S_MXL: begin
        acc_d   = AccW'(prod) + RoundC;
        state_d = S_MXH;
      end
      S_MXH: begin
        acc_d   = acc_q + (AccW'(prod) <<< LoW);
        dx_d    = acc_d[ShiftOut+PosW-1:ShiftOut];
        state_d = S_MYL;
      end
      S_MYL: begin
        acc_d   = AccW'(prod) + RoundC;
        state_d = S_MYH;
      end
      S_MYH: begin
        acc_d   = acc_q + (AccW'(prod) <<< LoW);
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold while the pen is down and the previous segment beat is still pending
        if (!(pen_q && seg_valid_q && !seg_o.ready)) begin
          pos_x_d = nx_w;
          pos_y_d = ny_w;
          if (pen_q) begin
            seg_valid_d = 1'b1;
            sx_d        = pos_x_q;
            sy_d        = pos_y_q;
            ex_d        = nx_w;
            ey_d        = ny_w;
          end
          state_d = S_IDLE;
        end
      end
      S_TURN: begin
        if (turn_q >= turn_w) begin
          turn_d = turn_q - turn_w;
        end
        iter_d = iter_q - 1'b1;
        if (iter_q == '0) begin
          heading_d = turn_d[HeadW-1:0];
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
      pen_q       <= 1'b1;
      seg_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      heading_q   <= heading_d;
      pen_q       <= pen_d;
      seg_valid_q <= seg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    iter_q <= iter_d;
    acc_q  <= acc_d;
    dx_q   <= dx_d;
    turn_q <= turn_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    ex_q   <= ex_d;
    ey_q   <= ey_d;
  end

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heading_q < HeadW'(FullTurn))
    else $error("heading left the range below 360 degrees");

  a_seg_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(seg_valid_q) |-> ($past(state_q) == S_DONE) && $past(pen_q))
    else $error("segment beat raised outside a pen-down move");

  a_turn_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TURN) |-> (iter_q < IterW'(TurnSteps)))
    else $error("turn reduction counter out of range");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import tpvs_pkg::*;

  typedef struct {
    op_e                    op;
    logic signed [PosW-1:0] amount;
    logic                   pen;
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic [HeadW-1:0]       hdg;
  } turtle_cmd_t;

  typedef struct {
    logic signed [PosW-1:0] sx;
    logic signed [PosW-1:0] sy;
    logic signed [PosW-1:0] ex;
    logic signed [PosW-1:0] ey;
  } segment_t;

  localparam logic signed [PosW-1:0] MaxQ = 24'sh7fffff;
  localparam logic signed [PosW-1:0] MinQ = 24'sh800000;
  localparam int RandomCmds = 1200;
  localparam int CalmTail   = 120;

  // atan(2^-i) in 2^-16 degree
  localparam longint AtanDeg16 [0:31] = '{
    2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  logic clk_i;
  logic rst_ni;

  tpvs_cmd_if cmd ();
  tpvs_seg_if seg ();

  turtle_pose_vector_stepper_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .seg_o  (seg)
  );

  turtle_cmd_t cmd_backlog[$];
  segment_t    segs_due[$];

  logic signed [PosW-1:0] pose_x;
  logic signed [PosW-1:0] pose_y;
  logic [HeadW-1:0]       heading;
  logic                   pen_down;

  turtle_cmd_t next_cmd;
  logic        cmd_taken;
  int          cmd_gap;
  int          seg_stall;
  int          idle_timer;
  logic        idle_on;
  int          cmds_accepted;
  int          cmds_total;
  int          errors;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // displacement of a Q16.8 distance along a heading, Q16.8
  function automatic void heading_offset(input logic signed [PosW-1:0] distance,
                                         input logic [HeadW-1:0] hdg,
                                         output longint dx, output longint dy);
    longint d, x, y, z, nx, h;
    d = longint'(distance) * 256;
    h = longint'(hdg);
    if (h >= HalfTurn) begin
      d = -d;
      h = h - HalfTurn;
    end
    x = 0;
    y = d;
    z = (h - QuarterTurn) * 512;
    for (int i = 0; i < CordicSteps && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - AtanDeg16[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + AtanDeg16[i];
      end
      x = nx;
    end
    dx = (x * longint'(GainQ30) + longint'(RoundC)) >>> ShiftOut;
    dy = (y * longint'(GainQ30) + longint'(RoundC)) >>> ShiftOut;
  endfunction

  task automatic execute_cmd(input turtle_cmd_t c);
    longint   dx, dy, t;
    segment_t s;
    case (c.op)
      OP_MOVE: begin
        heading_offset(c.amount, heading, dx, dy);
        s.sx = pose_x;
        s.sy = pose_y;
        s.ex = pose_x + dx[PosW-1:0];
        s.ey = pose_y + dy[PosW-1:0];
        if (pen_down) segs_due.push_back(s);
        pose_x = s.ex;
        pose_y = s.ey;
      end
      OP_TURN: begin
        t = (longint'(heading) + longint'(c.amount)) % FullTurn;
        if (t < 0) t = t + FullTurn;
        heading = t[HeadW-1:0];
      end
      OP_PEN: begin
        pen_down = c.pen;
      end
      default: begin
        pose_x  = c.x;
        pose_y  = c.y;
        heading = HeadW'(int'(c.hdg) % FullTurn);
      end
    endcase
  endtask

  task automatic push_cmd(input op_e op, input logic signed [PosW-1:0] amount,
                          input logic pen, input logic signed [PosW-1:0] x,
                          input logic signed [PosW-1:0] y, input logic [HeadW-1:0] hdg);
    turtle_cmd_t c;
    c.op     = op;
    c.amount = amount;
    c.pen    = pen;
    c.x      = x;
    c.y      = y;
    c.hdg    = hdg;
    cmd_backlog.push_back(c);
  endtask

  function automatic logic signed [PosW-1:0] rand_span();
    logic signed [PosW-1:0] r;
    r = PosW'($urandom);
    return r >>> $urandom_range(0, PosW - 1);
  endfunction

  // accept side: check returned segments, then advance the pose model
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cmd_taken <= cmd.valid && cmd.ready;
      if (seg.valid && seg.ready) begin
        if (segs_due.size() == 0) begin
          report_mismatch($sformatf("unexpected segment (%0d,%0d)-(%0d,%0d)",
                          seg.start_x, seg.start_y, seg.end_x, seg.end_y));
        end else begin
          segment_t e;
          e = segs_due.pop_front();
          if (seg.start_x !== e.sx)
            report_mismatch($sformatf("start_x %0d, want %0d", seg.start_x, e.sx));
          if (seg.start_y !== e.sy)
            report_mismatch($sformatf("start_y %0d, want %0d", seg.start_y, e.sy));
          if (seg.end_x !== e.ex)
            report_mismatch($sformatf("end_x %0d, want %0d", seg.end_x, e.ex));
          if (seg.end_y !== e.ey)
            report_mismatch($sformatf("end_y %0d, want %0d", seg.end_y, e.ey));
        end
      end
      if (cmd.valid && cmd.ready) begin
        turtle_cmd_t c;
        c.op     = op_e'(cmd.operation);
        c.amount = cmd.amount;
        c.pen    = cmd.pen_value;
        c.x      = cmd.pose_x;
        c.y      = cmd.pose_y;
        c.hdg    = cmd.pose_heading;
        execute_cmd(c);
        cmds_accepted++;
      end
    end
  end

  // drive side
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (idle_timer == 0) begin
        idle_on    = $urandom_range(0, 3) != 0;
        idle_timer = $urandom_range(100, 600);
      end else begin
        idle_timer--;
      end

      if (!cmd.valid || cmd_taken) begin
        if (cmd_gap != 0) begin
          cmd.valid <= 1'b0;
          cmd_gap--;
        end else if (cmd_backlog.size() != 0) begin
          next_cmd = cmd_backlog.pop_front();
          cmd.operation    <= next_cmd.op;
          cmd.amount       <= next_cmd.amount;
          cmd.pen_value    <= next_cmd.pen;
          cmd.pose_x       <= next_cmd.x;
          cmd.pose_y       <= next_cmd.y;
          cmd.pose_heading <= next_cmd.hdg;
          cmd.valid        <= 1'b1;
          if (idle_on && cmd_backlog.size() >= CalmTail && $urandom_range(0, 99) < 15)
            cmd_gap = $urandom_range(1, 15);
        end else begin
          cmd.valid <= 1'b0;
        end
      end

      if (seg_stall != 0) begin
        seg.ready <= 1'b0;
        seg_stall--;
      end else if (idle_on && cmd_backlog.size() >= CalmTail &&
                   $urandom_range(0, 99) < 10) begin
        seg.ready <= 1'b0;
        seg_stall = $urandom_range(0, 14);
      end else begin
        seg.ready <= 1'b1;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    turtle_cmd_t c;
    int          r;

    rst_ni           = 1'b0;
    cmd.valid        = 1'b0;
    cmd.operation    = OP_MOVE;
    cmd.amount       = '0;
    cmd.pen_value    = 1'b0;
    cmd.pose_x       = '0;
    cmd.pose_y       = '0;
    cmd.pose_heading = '0;
    seg.ready        = 1'b0;
    cmd_taken        = 1'b0;
    cmd_gap          = 0;
    seg_stall        = 0;
    idle_timer       = 0;
    idle_on          = 1'b0;
    cmds_accepted    = 0;
    errors           = 0;
    pose_x           = '0;
    pose_y           = '0;
    heading          = '0;
    pen_down         = 1'b1;

    // directed part
    push_cmd(OP_MOVE, 24'sd256, 1'b0, '0, '0, '0);
    push_cmd(OP_MOVE, 24'sd0, 1'b0, '0, '0, '0);
    push_cmd(OP_MOVE, -24'sd256, 1'b0, '0, '0, '0);
    push_cmd(OP_TURN, 24'sd11520, 1'b0, '0, '0, '0);
    push_cmd(OP_MOVE, MaxQ, 1'b0, '0, '0, '0);
    push_cmd(OP_TURN, MinQ, 1'b0, '0, '0, '0);
    push_cmd(OP_MOVE, MinQ, 1'b0, '0, '0, '0);
    push_cmd(OP_TURN, MaxQ, 1'b0, '0, '0, '0);
    push_cmd(OP_MOVE, 24'sd1000, 1'b0, '0, '0, '0);
    push_cmd(OP_POSE, '0, 1'b0, MaxQ, MinQ, 16'd0);
    push_cmd(OP_MOVE, 24'sd256, 1'b0, '0, '0, '0);
    push_cmd(OP_POSE, '0, 1'b0, MinQ, MaxQ, 16'hffff);
    push_cmd(OP_MOVE, 24'sd5000, 1'b0, '0, '0, '0);
    push_cmd(OP_POSE, MaxQ, 1'b1, 24'sd0, 24'sd0, 16'd46080);
    push_cmd(OP_MOVE, 24'sd777, 1'b0, '0, '0, '0);
    push_cmd(OP_POSE, '0, 1'b0, 24'sd100, -24'sd100, 16'd23040);
    push_cmd(OP_MOVE, 24'sd4096, 1'b0, '0, '0, '0);
    push_cmd(OP_POSE, '0, 1'b0, 24'sd0, 24'sd0, 16'd34560);
    push_cmd(OP_MOVE, -24'sd4096, 1'b0, '0, '0, '0);
    push_cmd(OP_POSE, '0, 1'b0, 24'sd0, 24'sd0, 16'd46079);
    push_cmd(OP_MOVE, MaxQ, 1'b0, '0, '0, '0);
    push_cmd(OP_PEN, MinQ, 1'b0, MaxQ, MaxQ, 16'hffff);
    push_cmd(OP_MOVE, 24'sd12345, 1'b0, '0, '0, '0);
    push_cmd(OP_PEN, '0, 1'b1, '0, '0, '0);
    push_cmd(OP_MOVE, -24'sd300, 1'b0, '0, '0, '0);

    // random part, mostly drawing with the pen down
    for (int n = 0; n < RandomCmds; n++) begin
      r        = $urandom_range(0, 99);
      c.amount = PosW'($urandom);
      c.pen    = 1'($urandom_range(0, 1));
      c.x      = PosW'($urandom);
      c.y      = PosW'($urandom);
      c.hdg    = HeadW'($urandom);
      if (r < 50) begin
        c.op     = OP_MOVE;
        c.amount = rand_span();
      end else if (r < 72) begin
        c.op = OP_TURN;
        if ($urandom_range(0, 1) != 0)
          c.amount = PosW'(($urandom_range(0, 1440) - 720) * 128);
        else
          c.amount = rand_span();
      end else if (r < 82) begin
        c.op  = OP_PEN;
        c.pen = $urandom_range(0, 3) != 0;
      end else begin
        c.op = OP_POSE;
        c.x  = rand_span();
        c.y  = rand_span();
        if ($urandom_range(0, 4) != 0) c.hdg = HeadW'($urandom_range(0, FullTurn - 1));
      end
      cmd_backlog.push_back(c);
    end
    cmds_total = cmd_backlog.size();

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmds_accepted < cmds_total || segs_due.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
